/* src/sfbf8_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfbf8_pkg
// Shared types and constants of the frame builder with Fletcher-8 checksum.
// ----------------------------------------------------------------------------
package sfbf8_pkg;

  localparam logic [7:0]  SYNC_FIRST     = 8'hB5;
  localparam logic [7:0]  SYNC_SECOND    = 8'h62;
  localparam int          CAP_W          = 17;
  localparam logic [16:0] CAP_RESET      = 17'd65543;
  localparam logic [16:0] FRAME_OVERHEAD = 17'd8;
  localparam int          MAX_BEATS      = 8;
  localparam int          BEAT_IDX_W     = $clog2(MAX_BEATS);

  typedef enum logic {
    OP_START   = 1'b0,
    OP_PAYLOAD = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERSIZE = 2'd1,
    ST_STRAY    = 2'd2
  } status_t;

  // One run of output beats caused by a single input item.
  typedef struct packed {
    logic [MAX_BEATS-1:0][7:0] bytes;
    logic [BEAT_IDX_W-1:0]     last;
    status_t                   status;
  } burst_t;

endpackage

/* src/sync_frame_builder_fletcher8.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_frame_builder_fletcher8
// Builds sync-prefixed command frames with a Fletcher-8 checksum as bytes.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries commands: tuser 0 is a start beat with class,
//   id and payload length, tuser 1 is one payload byte. The output stream
//   carries one frame byte per beat; tlast marks the final beat of the run
//   caused by one input beat, and tuser carries the status code.
//   The configuration channel writes the frame capacity in bytes; write it
//   only while no beats are in flight.
// Timing:
//   The first output beat of an item appears the cycle after it is taken.
//   An item yields 1 to 8 beats at one beat per cycle unless out_tready
//   is low; the next item is taken in the same cycle as the final beat
//   of the current run, so payload bytes stream at one per cycle. The
//   single result register holding one run sets this rate.
// Reset and stalls:
//   Reset closes any open frame, clears the sums and restores the capacity
//   to its maximum. Both ready outputs stay low while rst_n is low. While
//   out_tready is low the current beat holds and in_tready stays low.
// ----------------------------------------------------------------------------
module sync_frame_builder_fletcher8
  import sfbf8_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [16:0] cfg_data,    // max_frame_bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,    // msg_class, msg_id, payload_len, data_byte
  input  logic        in_tuser,    // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // out_byte
  output logic        out_tlast,
  output logic [1:0]  out_tuser    // status
);

  logic   in_take;
  logic   seq_free;
  burst_t burst;

  assign cfg_ready = rst_n;
  assign in_tready = seq_free && rst_n;
  assign in_take   = in_tvalid && in_tready;

  sfbf8_engine u_engine (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_value   (cfg_data),
    .item_accept (in_take),
    .opcode      (opcode_t'(in_tuser)),
    .msg_class   (in_tdata[7:0]),
    .msg_id      (in_tdata[15:8]),
    .payload_len (in_tdata[31:16]),
    .data_byte   (in_tdata[39:32]),
    .burst       (burst)
  );

  sfbf8_sequencer u_sequencer (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_take),
    .burst_in   (burst),
    .free       (seq_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

/* src/sfbf8_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfbf8_engine
// Frame state, checksum sums and capacity register; turns one accepted item
// into a burst of output bytes and updates the frame state at the same edge.
// ----------------------------------------------------------------------------
module sfbf8_engine
  import sfbf8_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_value,
  input  logic             item_accept,
  input  opcode_t          opcode,
  input  logic [7:0]       msg_class,
  input  logic [7:0]       msg_id,
  input  logic [15:0]      payload_len,
  input  logic [7:0]       data_byte,
  output burst_t           burst
);

  logic [CAP_W-1:0] max_frame_bytes_r;
  logic [7:0]       sum_a_r, sum_a_nxt;
  logic [7:0]       sum_b_r, sum_b_nxt;
  logic [15:0]      bytes_left_r, bytes_left_nxt;
  logic             in_frame_r, in_frame_nxt;

  always_comb begin
    logic [7:0]  a;
    logic [7:0]  b;
    logic [16:0] total;
    logic [15:0] left;
    a              = 8'd0;
    b              = 8'd0;
    total          = {1'b0, payload_len} + FRAME_OVERHEAD;
    left           = bytes_left_r - 16'd1;
    sum_a_nxt      = sum_a_r;
    sum_b_nxt      = sum_b_r;
    bytes_left_nxt = bytes_left_r;
    in_frame_nxt   = in_frame_r;
    burst.bytes    = '0;
    burst.last     = '0;
    burst.status   = ST_OK;
    case (opcode)
      OP_START: begin
        // A start always abandons whatever frame was open.
        sum_a_nxt      = 8'd0;
        sum_b_nxt      = 8'd0;
        bytes_left_nxt = 16'd0;
        in_frame_nxt   = 1'b0;
        if (max_frame_bytes_r < total) begin
          burst.status = ST_OVERSIZE;
        end else begin
          a = msg_class;         b = a;
          a = a + msg_id;        b = b + a;
          a = a + payload_len[7:0];  b = b + a;
          a = a + payload_len[15:8]; b = b + a;
          sum_a_nxt      = a;
          sum_b_nxt      = b;
          burst.bytes[0] = SYNC_FIRST;
          burst.bytes[1] = SYNC_SECOND;
          burst.bytes[2] = msg_class;
          burst.bytes[3] = msg_id;
          burst.bytes[4] = payload_len[7:0];
          burst.bytes[5] = payload_len[15:8];
          burst.bytes[6] = a;
          burst.bytes[7] = b;
          if (payload_len == 16'd0) begin
            burst.last = BEAT_IDX_W'(7);
          end else begin
            burst.last     = BEAT_IDX_W'(5);
            in_frame_nxt   = 1'b1;
            bytes_left_nxt = payload_len;
          end
        end
      end
      OP_PAYLOAD: begin
        if (!in_frame_r) begin
          burst.status = ST_STRAY;
        end else begin
          a              = sum_a_r + data_byte;
          b              = sum_b_r + a;
          sum_a_nxt      = a;
          sum_b_nxt      = b;
          bytes_left_nxt = left;
          burst.bytes[0] = data_byte;
          burst.bytes[1] = a;
          burst.bytes[2] = b;
          if (left == 16'd0) begin
            burst.last   = BEAT_IDX_W'(2);
            in_frame_nxt = 1'b0;
          end
        end
      end
      default: begin
        burst.status = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_frame_bytes_r <= CAP_RESET;
      sum_a_r           <= 8'd0;
      sum_b_r           <= 8'd0;
      bytes_left_r      <= 16'd0;
      in_frame_r        <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_frame_bytes_r <= cfg_value;
      end
      if (item_accept) begin
        sum_a_r      <= sum_a_nxt;
        sum_b_r      <= sum_b_nxt;
        bytes_left_r <= bytes_left_nxt;
        in_frame_r   <= in_frame_nxt;
      end
    end
  end

endmodule

/* src/sfbf8_sequencer.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfbf8_sequencer
// Holds one burst in the result register and hands it out one beat at a time.
// ----------------------------------------------------------------------------
module sfbf8_sequencer
  import sfbf8_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  burst_t     burst_in,
  output logic       free,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,
  output logic       out_tlast,
  output logic [1:0] out_tuser
);

  burst_t                burst_r;
  logic [BEAT_IDX_W-1:0] idx_r;
  logic                  valid_r;
  logic                  take;
  logic                  last_beat;

  assign take      = valid_r && out_tready;
  assign last_beat = (idx_r == burst_r.last);
  // The next burst may load in the cycle the final beat of this one leaves.
  assign free      = !valid_r || (take && last_beat);

  assign out_tvalid = valid_r;
  assign out_tdata  = burst_r.bytes[idx_r];
  assign out_tlast  = last_beat;
  assign out_tuser  = burst_r.status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      idx_r   <= '0;
    end else if (load) begin
      valid_r <= 1'b1;
      idx_r   <= '0;
    end else if (take) begin
      if (last_beat) begin
        valid_r <= 1'b0;
      end else begin
        idx_r <= idx_r + BEAT_IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      burst_r <= burst_in;
    end
  end

endmodule
